### rtl/core/bounded_ordered_set_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the ordered set block
// Shared property shapes, clocked on clk_i and held off during reset.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_ORDERED_SET_TOP_MACROS_SVH
`define BOUNDED_ORDERED_SET_TOP_MACROS_SVH

// same-cycle implication
`define BOS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BOS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/bos_pkg.sv
// ----------------------------------------------------------------------------
// bos_pkg
// Geometry, opcodes, shared types and bit-scan helpers of the ordered set.
// ----------------------------------------------------------------------------
package bos_pkg;

  localparam int unsigned UNIVERSE = 32;
  localparam int unsigned KEY_W    = $clog2(UNIVERSE);
  localparam int unsigned CL_W     = KEY_W / 2;
  localparam int unsigned CSIZE    = 1 << CL_W;
  localparam int unsigned NCL      = UNIVERSE / CSIZE;
  localparam int unsigned CIDX_W   = KEY_W - CL_W;
  localparam int unsigned FUNC_W   = 3;

  typedef enum logic [FUNC_W-1:0] {
    OP_INSERT = 3'd0,
    OP_DELETE = 3'd1,
    OP_MEMBER = 3'd2,
    OP_SUCC   = 3'd3,
    OP_PRED   = 3'd4
  } op_e;

  typedef logic [CSIZE-1:0] word_t;

  typedef struct packed {
    logic              hit;
    logic [CL_W-1:0]   idx;
  } pos_t;

  typedef struct packed {
    logic              we;
    logic [CIDX_W-1:0] idx;
    logic              val;
  } sum_upd_t;

  typedef struct packed {
    logic              nxt_hit;
    logic [CIDX_W-1:0] nxt_idx;
    logic              prv_hit;
    logic [CIDX_W-1:0] prv_idx;
  } sum_srch_t;

  // bits strictly above pos
  function automatic word_t above_mask(logic [CL_W-1:0] pos);
    word_t m;
    m = '0;
    for (int i = 0; i < CSIZE; i++) begin
      m[i] = (CL_W'(i) > pos);
    end
    return m;
  endfunction

  // bits at or below pos
  function automatic word_t upto_mask(logic [CL_W-1:0] pos);
    word_t m;
    m = '0;
    for (int i = 0; i < CSIZE; i++) begin
      m[i] = (CL_W'(i) <= pos);
    end
    return m;
  endfunction

  function automatic pos_t first_set(word_t w);
    pos_t p;
    p = '0;
    for (int i = CSIZE - 1; i >= 0; i--) begin
      if (w[i]) begin
        p.hit = 1'b1;
        p.idx = CL_W'(i);
      end
    end
    return p;
  endfunction

  function automatic pos_t last_set(word_t w);
    pos_t p;
    p = '0;
    for (int i = 0; i < CSIZE; i++) begin
      if (w[i]) begin
        p.hit = 1'b1;
        p.idx = CL_W'(i);
      end
    end
    return p;
  endfunction

endpackage

### rtl/core/bos_ram.sv
// ----------------------------------------------------------------------------
// bos_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bos_ram #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/bos_summary.sv
// ----------------------------------------------------------------------------
// bos_summary
// One occupancy bit per cluster, plus nearest occupied cluster above/below.
// ----------------------------------------------------------------------------
module bos_summary (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  bos_pkg::sum_upd_t              upd_i,
  input  logic [bos_pkg::CIDX_W-1:0]     rd_idx_i,
  output logic                           rd_bit_o,
  input  logic [bos_pkg::CIDX_W-1:0]     cl_i,
  output bos_pkg::sum_srch_t             srch_o
);

  logic [bos_pkg::NCL-1:0] sum_q;
  logic [bos_pkg::NCL-1:0] sum_d;

  always_comb begin
    sum_d = sum_q;
    if (upd_i.we) begin
      sum_d[upd_i.idx] = upd_i.val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else begin
      sum_q <= sum_d;
    end
  end

  assign rd_bit_o = sum_q[rd_idx_i];

  always_comb begin
    srch_o = '0;
    for (int i = bos_pkg::NCL - 1; i >= 0; i--) begin
      if (sum_q[i] && (bos_pkg::CIDX_W'(i) > cl_i)) begin
        srch_o.nxt_hit = 1'b1;
        srch_o.nxt_idx = bos_pkg::CIDX_W'(i);
      end
    end
    for (int i = 0; i < bos_pkg::NCL; i++) begin
      if (sum_q[i] && (bos_pkg::CIDX_W'(i) < cl_i)) begin
        srch_o.prv_hit = 1'b1;
        srch_o.prv_idx = bos_pkg::CIDX_W'(i);
      end
    end
  end

endmodule

### rtl/core/bounded_ordered_set_top.sv
// ----------------------------------------------------------------------------
// bounded_ordered_set_top
// Ordered key set with insert, delete, member, successor and predecessor.
//
//   channel  dir  handshake                 payload
//   in       in   in_valid_i / in_stall_o   func_i, key_i
//   out      out  out_valid_o / out_stall_i found_o, value_o
//
// One request at a time. Insert, delete, member and a neighbor found in the
// key's own cluster pass through accept and then the cluster word read; a
// neighbor in another cluster adds a second read of the cluster-word RAM in
// the scan state. The result register may hold while the next request is
// accepted; a request finishes only once that register is free.
// After reset the set is empty and a request can be accepted at once.
// ----------------------------------------------------------------------------
`include "bounded_ordered_set_top_macros.svh"

module bounded_ordered_set_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [bos_pkg::FUNC_W-1:0]   func_i,
  input  logic [bos_pkg::KEY_W-1:0]    key_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         found_o,
  output logic [bos_pkg::KEY_W-1:0]    value_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOOK = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;

  logic [1:0]                       state_q, state_d;
  logic [bos_pkg::FUNC_W-1:0]       func_q;
  logic [bos_pkg::KEY_W-1:0]        ptr_q, ptr_d;
  logic                             nil_q;
  logic                             sumv_q, sumv_d;

  logic                             out_valid_q;
  logic                             found_q, found_d;
  logic [bos_pkg::KEY_W-1:0]        value_q, value_d;
  logic                             res_v;
  logic                             out_free;
  logic                             acc;

  logic                             ram_we, ram_re;
  logic [bos_pkg::CIDX_W-1:0]       ram_raddr;
  bos_pkg::word_t                   ram_wdata, ram_rdata, word, onehot;
  bos_pkg::pos_t                    pos_lo, pos_hi, pos_scan;

  logic [bos_pkg::KEY_W-1:0]        key_m1;
  logic [bos_pkg::CL_W-1:0]         low;
  logic [bos_pkg::CIDX_W-1:0]       cl;
  logic                             rd_bit;
  bos_pkg::sum_upd_t                upd;
  bos_pkg::sum_srch_t               srch;

  assign acc        = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;

  assign key_m1 = key_i - bos_pkg::KEY_W'(1);
  assign low    = ptr_q[bos_pkg::CL_W-1:0];
  assign cl     = ptr_q[bos_pkg::KEY_W-1:bos_pkg::CL_W];
  assign word   = ram_rdata & {bos_pkg::CSIZE{sumv_q}};
  assign onehot = bos_pkg::word_t'(1) << low;

  assign pos_hi   = bos_pkg::first_set(word & bos_pkg::above_mask(low));
  assign pos_lo   = bos_pkg::last_set(word & bos_pkg::upto_mask(low));
  assign pos_scan = (func_q == bos_pkg::OP_SUCC) ? bos_pkg::first_set(word)
                                                 : bos_pkg::last_set(word);

  always_comb begin
    state_d   = state_q;
    ptr_d     = ptr_q;
    sumv_d    = sumv_q;
    ram_re    = 1'b0;
    ram_raddr = ptr_q[bos_pkg::KEY_W-1:bos_pkg::CL_W];
    ram_we    = 1'b0;
    ram_wdata = word;
    upd       = '0;
    upd.idx   = cl;
    res_v     = 1'b0;
    found_d   = 1'b0;
    value_d   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (acc) begin
          ptr_d     = (func_i == bos_pkg::OP_PRED) ? key_m1 : key_i;
          ram_re    = 1'b1;
          ram_raddr = ptr_d[bos_pkg::KEY_W-1:bos_pkg::CL_W];
          sumv_d    = rd_bit;
          state_d   = ST_LOOK;
        end
      end
      ST_LOOK: begin
        unique case (func_q)
          bos_pkg::OP_INSERT, bos_pkg::OP_DELETE: begin
            if (out_free) begin
              ram_we    = 1'b1;
              ram_wdata = (func_q == bos_pkg::OP_INSERT) ? (word | onehot)
                                                         : (word & ~onehot);
              upd.we    = 1'b1;
              upd.val   = |ram_wdata;
              res_v     = 1'b1;
              found_d   = word[low];
              state_d   = ST_IDLE;
            end
          end
          bos_pkg::OP_MEMBER: begin
            if (out_free) begin
              res_v   = 1'b1;
              found_d = word[low];
              state_d = ST_IDLE;
            end
          end
          bos_pkg::OP_SUCC: begin
            if (pos_hi.hit) begin
              if (out_free) begin
                res_v   = 1'b1;
                found_d = 1'b1;
                value_d = {cl, pos_hi.idx};
                state_d = ST_IDLE;
              end
            end else if (srch.nxt_hit) begin
              ram_re    = 1'b1;
              ram_raddr = srch.nxt_idx;
              ptr_d     = {srch.nxt_idx, low};
              sumv_d    = 1'b1;
              state_d   = ST_SCAN;
            end else if (out_free) begin
              res_v   = 1'b1;
              state_d = ST_IDLE;
            end
          end
          bos_pkg::OP_PRED: begin
            if (!nil_q && pos_lo.hit) begin
              if (out_free) begin
                res_v   = 1'b1;
                found_d = 1'b1;
                value_d = {cl, pos_lo.idx};
                state_d = ST_IDLE;
              end
            end else if (!nil_q && srch.prv_hit) begin
              ram_re    = 1'b1;
              ram_raddr = srch.prv_idx;
              ptr_d     = {srch.prv_idx, low};
              sumv_d    = 1'b1;
              state_d   = ST_SCAN;
            end else if (out_free) begin
              res_v   = 1'b1;
              state_d = ST_IDLE;
            end
          end
          default: begin
            if (out_free) begin
              res_v   = 1'b1;
              state_d = ST_IDLE;
            end
          end
        endcase
      end
      ST_SCAN: begin
        if (out_free) begin
          res_v   = 1'b1;
          found_d = 1'b1;
          value_d = {cl, pos_scan.idx};
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (res_v) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q  <= ptr_d;
    sumv_q <= sumv_d;
    if (acc) begin
      func_q <= func_i;
      nil_q  <= (func_i == bos_pkg::OP_PRED) && (key_i == '0);
    end
    if (res_v) begin
      found_q <= found_d;
      value_q <= value_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign found_o     = found_q;
  assign value_o     = value_q;

  bos_ram #(
    .WIDTH (bos_pkg::CSIZE),
    .DEPTH (bos_pkg::NCL)
  ) u_words (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cl),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  bos_summary u_summary (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .upd_i    (upd),
    .rd_idx_i (ram_raddr),
    .rd_bit_o (rd_bit),
    .cl_i     (cl),
    .srch_o   (srch)
  );

  // occupied cluster must hold a key in RAM
  `BOS_ASSERT_NOW(a_sum_word, (state_q != ST_IDLE) && sumv_q, ram_rdata != '0, "empty word")
  // second read only follows an occupied-cluster hit
  `BOS_ASSERT_NOW(a_scan_hit, state_q == ST_SCAN, pos_scan.hit, "scan found no key")
  // writes come only from a finishing lookup
  `BOS_ASSERT_NOW(a_wr_look, ram_we, (state_q == ST_LOOK) && res_v, "stray word write")
  // an accepted request always reads its cluster next
  `BOS_ASSERT_NEXT(a_acc_look, acc, state_q == ST_LOOK, "accept not followed by lookup")

endmodule

### verif/bounded_ordered_set_top_tb.sv
// ----------------------------------------------------------------------------
// bounded_ordered_set_top_tb
// Drives insert, delete, member, successor, predecessor and unused opcodes
// into the ordered key set and checks every answer against a bit-vector copy
// of the set kept in the bench. Both handshake sides idle at random. The
// receiver also holds off for long stretches so that the block backs up.
// ----------------------------------------------------------------------------
module bounded_ordered_set_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bos_pkg::*;

  localparam logic [FUNC_W-1:0] OP_UNUSED_5 = 3'd5;
  localparam logic [FUNC_W-1:0] OP_UNUSED_6 = 3'd6;
  localparam logic [FUNC_W-1:0] OP_UNUSED_7 = 3'd7;

  localparam int RANDOM_REQS = 1200;
  localparam int CALM_FROM   = 400;
  localparam int CALM_TO     = 550;
  localparam int HOLD_AT_A   = 300;
  localparam int HOLD_AT_B   = 900;
  localparam int HOLD_CYCLES = 150;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [KEY_W-1:0]  key;
  } set_req_t;

  typedef struct packed {
    logic             found;
    logic [KEY_W-1:0] value;
  } set_ans_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [FUNC_W-1:0] func = '0;
  logic [KEY_W-1:0]  key = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              found;
  logic [KEY_W-1:0]  value;

  set_req_t        pending_reqs[$];
  set_ans_t        predicted_answers[$];
  logic [UNIVERSE-1:0] key_set = '0;
  int              errors = 0;
  int              accepted = 0;
  int              answered = 0;
  int              gap_left = 0;
  int              hold_left = 0;
  int              last_hold_at = -1;
  int              stall_run = 0;
  logic            stall_level = 1'b0;

  bounded_ordered_set_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .func_i      (func),
    .key_i       (key),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .found_o     (found),
    .value_o     (value)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // applies one request to the bench copy of the set and returns the answer
  function automatic set_ans_t set_lookup(input logic [FUNC_W-1:0] f,
                                          input logic [KEY_W-1:0] k);
    set_ans_t a;
    a = '0;
    case (f)
      OP_INSERT: begin
        a.found = key_set[k];
        key_set[k] = 1'b1;
      end
      OP_DELETE: begin
        a.found = key_set[k];
        key_set[k] = 1'b0;
      end
      OP_MEMBER: a.found = key_set[k];
      OP_SUCC: begin
        for (int i = int'(k) + 1; i < UNIVERSE; i++) begin
          if (key_set[i] && !a.found) begin
            a.found = 1'b1;
            a.value = KEY_W'(i);
          end
        end
      end
      OP_PRED: begin
        for (int i = int'(k) - 1; i >= 0; i--) begin
          if (key_set[i] && !a.found) begin
            a.found = 1'b1;
            a.value = KEY_W'(i);
          end
        end
      end
      default: a = '0;
    endcase
    return a;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (accepted >= CALM_FROM && accepted < CALM_TO) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  task automatic queue_req(input logic [FUNC_W-1:0] f, input logic [KEY_W-1:0] k);
    set_req_t r;
    r.func = f;
    r.key  = k;
    pending_reqs.push_back(r);
  endtask

  // request driver
  always @(posedge clk_i) begin
    logic     fire;
    set_req_t r;
    if (rst_ni) begin
      fire = in_valid && !in_stall;
      if (fire) begin
        predicted_answers.push_back(set_lookup(func, key));
        accepted++;
      end
      if (!in_valid || fire) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          r = pending_reqs.pop_front();
          in_valid <= 1'b1;
          func     <= r.func;
          key      <= r.key;
          gap_left = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // answer monitor and receiver stall
  always @(posedge clk_i) begin
    set_ans_t exp_ans;
    logic     nxt;
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        if (predicted_answers.size() == 0) begin
          $display("%0t: unexpected answer found=%0b value=%0d", $realtime, found, value);
          errors++;
        end else begin
          exp_ans = predicted_answers.pop_front();
          if (found !== exp_ans.found) begin
            $display("%0t: found mismatch, expected %0b actual %0b",
                     $realtime, exp_ans.found, found);
            errors++;
          end
          if (value !== exp_ans.value) begin
            $display("%0t: value mismatch, expected %0d actual %0d",
                     $realtime, exp_ans.value, value);
            errors++;
          end
        end
        answered++;
      end
      if ((answered == HOLD_AT_A || answered == HOLD_AT_B) && last_hold_at != answered) begin
        last_hold_at = answered;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        nxt = 1'b1;
      end else if (accepted >= CALM_FROM && accepted < CALM_TO) begin
        nxt = 1'b0;
      end else begin
        if (stall_run == 0) begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
              stall_level = 1'b0;
              stall_run = $urandom_range(1, 20);
            end
            9: begin
              stall_level = 1'b1;
              stall_run = $urandom_range(10, 40);
            end
            default: begin
              stall_level = 1'b1;
              stall_run = $urandom_range(1, 3);
            end
          endcase
        end
        stall_run--;
        nxt = stall_level;
      end
      out_stall <= nxt;
    end
  end

  initial begin
    int n;
    int ins_w;
    int r;
    logic [FUNC_W-1:0] f;
    logic [KEY_W-1:0]  k;

    // empty set, edges, cross-cluster search, duplicate insert, absent delete, unused opcodes
    queue_req(OP_MEMBER, 5'd0);
    queue_req(OP_SUCC, 5'd0);
    queue_req(OP_PRED, 5'd31);
    queue_req(OP_INSERT, 5'd0);
    queue_req(OP_INSERT, 5'd31);
    queue_req(OP_INSERT, 5'd0);
    queue_req(OP_SUCC, 5'd0);
    queue_req(OP_PRED, 5'd31);
    queue_req(OP_SUCC, 5'd31);
    queue_req(OP_PRED, 5'd0);
    queue_req(OP_INSERT, 5'd5);
    queue_req(OP_SUCC, 5'd4);
    queue_req(OP_PRED, 5'd7);
    queue_req(OP_DELETE, 5'd9);
    queue_req(OP_DELETE, 5'd5);
    queue_req(OP_DELETE, 5'd5);
    queue_req(OP_MEMBER, 5'd31);
    queue_req(OP_UNUSED_5, 5'd31);
    queue_req(OP_UNUSED_6, 5'd0);
    queue_req(OP_UNUSED_7, 5'd21);
    queue_req(OP_INSERT, 5'd10);
    queue_req(OP_PRED, 5'd15);
    queue_req(OP_SUCC, 5'd0);
    queue_req(OP_DELETE, 5'd0);
    queue_req(OP_DELETE, 5'd31);

    n = 0;
    ins_w = 30;
    while (n < RANDOM_REQS) begin
      if (n % 150 == 0) ins_w = $urandom_range(15, 40);
      r = $urandom_range(0, 99);
      k = (r < 5) ? 5'd0 : (r < 10) ? 5'd31 : KEY_W'($urandom_range(0, UNIVERSE - 1));
      r = $urandom_range(0, 99);
      if (r < 3) begin
        case ($urandom_range(0, 2))
          0: f = OP_UNUSED_5;
          1: f = OP_UNUSED_6;
          default: f = OP_UNUSED_7;
        endcase
      end else begin
        r = $urandom_range(0, 99);
        if (r < ins_w) f = OP_INSERT;
        else if (r < 50) f = OP_DELETE;
        else if (r < 66) f = OP_MEMBER;
        else if (r < 83) f = OP_SUCC;
        else f = OP_PRED;
        n++;
      end
      queue_req(f, k);
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_reqs.size() > 0 || in_valid) @(posedge clk_i);
    while (predicted_answers.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/bos_pkg.sv
rtl/core/bos_ram.sv
rtl/core/bos_summary.sv
rtl/core/bounded_ordered_set_top.sv
verif/bounded_ordered_set_top_tb.sv
